[src/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the Solovay-Strassen prime test block.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int FIELD_WIDTH = 32;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] candidate;
      logic [FIELD_WIDTH-1:0] witness;
      logic                   last_trial;
   } req_type;

   typedef struct packed {
      logic probably_prime;
      logic bad_witness;
      logic test_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_JAC,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_FINISH
   } state_type;

   localparam logic [2:0] MOD8_THREE = 3'd3;
   localparam logic [2:0] MOD8_FIVE  = 3'd5;
   localparam logic [1:0] MOD4_THREE = 2'd3;

endpackage

[src/solovay_strassen_prime_test.sv]
// ----------------------------------------------------------------------------
// solovay_strassen_prime_test
// One Solovay-Strassen trial per request, running verdict per result.
// ----------------------------------------------------------------------------
// A trial for an odd candidate n with a base in 2..n-1 takes one binary
// Jacobi step per cycle, then the power base^((n-1)/2) mod n by square
// and multiply: NUM_WIDTH squarings and up to NUM_WIDTH multiplications
// on one bit-serial modular multiplier. Trivial candidates and
// out-of-range bases go from idle straight to the finish state. One
// request is in work at a time; a finished result waits in the output
// register while the next request is taken.
module solovay_strassen_prime_test #(
   parameter int NUM_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssp_pkg::rsp_type rsp_data
);
   import ssp_pkg::*;

   localparam int CW = $clog2(NUM_WIDTH);

   state_type            state_ff, state_in;
   logic                 still_ff, still_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [NUM_WIDTH-1:0] n_ff, n_in;
   logic [NUM_WIDTH-1:0] a_ff, a_in;
   logic                 last_ff, last_in;
   logic                 fail_ff, fail_in;
   logic                 bad_ff, bad_in;
   logic [NUM_WIDTH-1:0] ja_ff, ja_in;
   logic [NUM_WIDTH-1:0] jn_ff, jn_in;
   logic                 sign_ff, sign_in;
   logic [NUM_WIDTH-1:0] r_ff, r_in;
   logic [NUM_WIDTH-1:0] e_sr_ff, e_sr_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] rn, ra, nm1, mm_y;
   logic                 pass;
   logic                 mm_start;
   logic                 mm_done;
   logic [NUM_WIDTH-1:0] mm_prod;

   ssp_modmul #(.NUM_WIDTH(NUM_WIDTH)) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .done    (mm_done),
      .x       (r_ff),
      .y       (mm_y),
      .m       (n_ff),
      .product (mm_prod)
   );

   assign rn  = req_data.candidate[NUM_WIDTH-1:0];
   assign ra  = req_data.witness[NUM_WIDTH-1:0];
   assign nm1 = n_ff - 1'b1;
   assign mm_y = (state_ff == ST_MUL_GO) ? a_ff : r_ff;
   assign pass = sign_ff ? (r_ff == nm1) : (r_ff == NUM_WIDTH'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         still_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         still_ff     <= still_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff  <= rsp_in;
      n_ff    <= n_in;
      a_ff    <= a_in;
      last_ff <= last_in;
      fail_ff <= fail_in;
      bad_ff  <= bad_in;
      ja_ff   <= ja_in;
      jn_ff   <= jn_in;
      sign_ff <= sign_in;
      r_ff    <= r_in;
      e_sr_ff <= e_sr_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in     = state_ff;
      still_in     = still_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      last_in      = last_ff;
      fail_in      = fail_ff;
      bad_in       = bad_ff;
      ja_in        = ja_ff;
      jn_in        = jn_ff;
      sign_in      = sign_ff;
      r_in         = r_ff;
      e_sr_in      = e_sr_ff;
      cnt_in       = cnt_ff;
      mm_start     = 1'b0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in    = rn;
               a_in    = ra;
               last_in = req_data.last_trial;
               ja_in   = ra;
               jn_in   = rn;
               sign_in = 1'b0;
               fail_in = 1'b0;
               bad_in  = 1'b0;
               state_in = ST_FINISH;
               if (rn < NUM_WIDTH'(2)) begin
                  fail_in = 1'b1;
               end else if (rn == NUM_WIDTH'(2)) begin
                  fail_in = 1'b0;
               end else if (!rn[0]) begin
                  fail_in = 1'b1;
               end else if (ra < NUM_WIDTH'(2) || ra >= rn) begin
                  bad_in = 1'b1;
               end else begin
                  state_in = ST_JAC;
               end
            end
         end
         ST_JAC: begin
            if (ja_ff == '0) begin
               if (jn_ff != NUM_WIDTH'(1)) begin
                  fail_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  r_in     = NUM_WIDTH'(1);
                  e_sr_in  = nm1 >> 1;
                  cnt_in   = CW'(NUM_WIDTH - 1);
                  state_in = ST_SQ_GO;
               end
            end else if (!ja_ff[0]) begin
               ja_in = ja_ff >> 1;
               if (jn_ff[2:0] == MOD8_THREE || jn_ff[2:0] == MOD8_FIVE) begin
                  sign_in = ~sign_ff;
               end
            end else if (ja_ff < jn_ff) begin
               ja_in = jn_ff;
               jn_in = ja_ff;
               if (ja_ff[1:0] == MOD4_THREE && jn_ff[1:0] == MOD4_THREE) begin
                  sign_in = ~sign_ff;
               end
            end else begin
               ja_in = ja_ff - jn_ff;
            end
         end
         ST_SQ_GO: begin
            mm_start = 1'b1;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (mm_done) begin
               r_in = mm_prod;
               if (e_sr_ff[NUM_WIDTH-1]) begin
                  state_in = ST_MUL_GO;
               end else begin
                  state_in = ST_MUL_WAIT;
               end
            end
         end
         ST_MUL_GO: begin
            mm_start = 1'b1;
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mm_done || !e_sr_ff[NUM_WIDTH-1]) begin
               if (mm_done) begin
                  r_in = mm_prod;
               end
               e_sr_in = {e_sr_ff[NUM_WIDTH-2:0], 1'b0};
               cnt_in  = cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_FINISH;
                  fail_in  = 1'b1;
                  if (mm_done) begin
                     fail_in = sign_ff ? (mm_prod != nm1) : (mm_prod != NUM_WIDTH'(1));
                  end else begin
                     fail_in = !pass;
                  end
               end else begin
                  state_in = ST_SQ_GO;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.probably_prime = still_ff & ~fail_ff;
               rsp_in.bad_witness    = bad_ff;
               rsp_in.test_done      = last_ff;
               still_in = last_ff ? 1'b1 : (still_ff & ~fail_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/ssp_modmul.sv]
// ----------------------------------------------------------------------------
// ssp_modmul
// Bit-serial modular multiplier: x*y mod m, a double and an add per y bit.
// ----------------------------------------------------------------------------
module ssp_modmul #(
   parameter int NUM_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 done,
   input  logic [NUM_WIDTH-1:0] x,
   input  logic [NUM_WIDTH-1:0] y,
   input  logic [NUM_WIDTH-1:0] m,
   output logic [NUM_WIDTH-1:0] product
);
   localparam int CW = $clog2(NUM_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 phase_ff, phase_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] y_sr_ff, y_sr_in;
   logic [NUM_WIDTH-1:0] x_ff, x_in;
   logic [NUM_WIDTH:0]   t;

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      y_sr_in  = y_sr_ff;
      x_in     = x_ff;
      t        = '0;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         cnt_in   = CW'(NUM_WIDTH - 1);
         acc_in   = '0;
         y_sr_in  = y;
         x_in     = x;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            t = {acc_ff, 1'b0};
            phase_in = 1'b1;
         end else begin
            t = {1'b0, acc_ff} + (y_sr_ff[NUM_WIDTH-1] ? {1'b0, x_ff} : '0);
            phase_in = 1'b0;
            y_sr_in  = {y_sr_ff[NUM_WIDTH-2:0], 1'b0};
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
         if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
         end
         acc_in = t[NUM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      y_sr_ff  <= y_sr_in;
      x_ff     <= x_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
